// File: rtl/floppy_softswitch_controller_defines.svh
// Assertion helpers shared by the controller RTL.
`ifndef FLOPPY_SOFTSWITCH_CONTROLLER_DEFINES_SVH
`define FLOPPY_SOFTSWITCH_CONTROLLER_DEFINES_SVH

// Clocked check, disabled while reset is asserted.
`define FSSC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define FSSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/fssc_pkg.sv
`timescale 1ns / 1ps
package fssc_pkg;

	localparam int TICKS_W = 24;

	// request codes
	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	// control line positions
	localparam logic [2:0] LN_PH1   = 3'd1;
	localparam logic [2:0] LN_PH3   = 3'd3;
	localparam logic [2:0] LN_MOTOR = 3'd4;
	localparam logic [2:0] LN_DRIVE = 3'd5;
	localparam logic [2:0] LN_Q6    = 3'd6;
	localparam logic [2:0] LN_Q7    = 3'd7;

	// soft-switch addresses with a data path action
	localparam logic [3:0] SW_MOTOR_OFF  = 4'd8;
	localparam logic [3:0] SW_MOTOR_ON   = 4'd9;
	localparam logic [3:0] SW_SEL_FIRST  = 4'd10;
	localparam logic [3:0] SW_SEL_SECOND = 4'd11;
	localparam logic [3:0] SW_DATA       = 4'd12;
	localparam logic [3:0] SW_LATCH      = 4'd13;
	localparam logic [3:0] SW_STATUS_ALT = 4'd14;

	// {Q7,Q6} register select in the integrated controller
	localparam logic [1:0] SEL_DATA      = 2'b00;
	localparam logic [1:0] SEL_STATUS    = 2'b01;
	localparam logic [1:0] SEL_HANDSHAKE = 2'b10;
	localparam logic [1:0] SEL_MODE      = 2'b11;

	localparam int MODE_FAST_OFF = 2;

	localparam logic [1:0] EN_NONE   = 2'd0;
	localparam logic [1:0] EN_FIRST  = 2'd1;
	localparam logic [1:0] EN_SECOND = 2'd2;

	localparam logic [7:0] STAT_SENSE = 8'h80;
	localparam logic [7:0] STAT_MOTOR = 8'h20;
	localparam logic [7:0] HS_BUSY    = 8'hC0;
	localparam logic [7:0] HS_READY   = 8'h80;
	localparam logic [7:0] BYTE_ALL   = 8'hFF;

	localparam logic [4:0]         MODE_RESET  = 5'h1F;
	localparam logic [TICKS_W-1:0] TICKS_RESET = 24'd1000000;

	// configuration register index
	localparam logic REG_KIND  = 1'b0;
	localparam logic REG_TICKS = 1'b1;

	typedef struct packed {
		logic [1:0] req_type;
		logic [3:0] switch_offset;
		logic [7:0] bus_data;
		logic [7:0] drive_byte;
		logic       drive_sense;
	} item_t;

	typedef struct packed {
		logic [7:0] read_value;
		logic       phase_update;
		logic [3:0] phase_lines;
		logic       enable_update;
		logic [1:0] drive_enables;
		logic       drive_write;
		logic [7:0] drive_write_byte;
		logic       drive_read_taken;
	} result_t;

	typedef struct packed {
		logic               controller_kind;
		logic [TICKS_W-1:0] motor_off_ticks;
	} cfg_t;

endpackage

// File: rtl/fssc_engine.sv
`timescale 1ns / 1ps
`include "floppy_softswitch_controller_defines.svh"
module fssc_engine #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step_en,
	input  fssc_pkg::item_t item,
	input  fssc_pkg::cfg_t  cfg,
	output fssc_pkg::result_t result
);
	import fssc_pkg::*;

	logic [7:0]             ctrl_q, ctrl_d;
	logic [4:0]             mode_q, mode_d;
	logic [7:0]             wlatch_q, wlatch_d;
	logic [1:0]             hs_q, hs_d;
	logic                   pend_q, pend_d;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;

	logic [31:0]            ticks_ext;
	logic [COUNT_WIDTH-1:0] delay;
	logic [COUNT_WIDTH-1:0] cnt_dec;

	assign ticks_ext = 32'(cfg.motor_off_ticks);
	assign delay     = ticks_ext[COUNT_WIDTH-1:0];
	assign cnt_dec   = cnt_q - COUNT_WIDTH'(1);

	always_comb begin
		logic [7:0] lines;
		logic       pair;
		logic [7:0] status;
		logic       ev_on, ev_off;
		logic [1:0] hs_inc;

		ctrl_d   = ctrl_q;
		mode_d   = mode_q;
		wlatch_d = wlatch_q;
		hs_d     = hs_q;
		pend_d   = pend_q;
		cnt_d    = cnt_q;
		result   = '0;
		ev_on    = 1'b0;
		ev_off   = 1'b0;

		lines = ctrl_q;
		lines[item.switch_offset[3:1]] = item.switch_offset[0];
		pair   = lines[LN_PH1] & lines[LN_PH3];
		status = (pair | item.drive_sense) ? STAT_SENSE : 8'h00;
		if (cfg.controller_kind)
			status = status | (lines[LN_MOTOR] ? STAT_MOTOR : 8'h00) | {3'b000, mode_q};
		hs_inc = hs_q + 2'd1;

		case (item.req_type) inside
			REQ_TICK: begin
				if (pend_q) begin
					cnt_d = cnt_dec;
					if (cnt_dec == '0) begin
						pend_d                 = 1'b0;
						ctrl_d[LN_MOTOR]       = 1'b0;
						result.enable_update   = 1'b1;
						result.drive_enables   = cfg.controller_kind ? EN_NONE :
							(ctrl_q[LN_DRIVE] ? EN_SECOND : EN_FIRST);
					end
				end
			end
			REQ_READ, REQ_WRITE: begin
				ctrl_d              = lines;
				result.phase_update = ~item.switch_offset[3];

				if (item.switch_offset == SW_MOTOR_OFF) begin
					if (mode_q[MODE_FAST_OFF] || delay == '0) begin
						ev_off = 1'b1;
					end else begin
						pend_d = 1'b1;
						cnt_d  = delay;
					end
				end else if (item.switch_offset == SW_MOTOR_ON) begin
					ev_on = 1'b1;
				end else if ((item.switch_offset == SW_SEL_FIRST ||
						item.switch_offset == SW_SEL_SECOND) && lines[LN_MOTOR]) begin
					result.enable_update = 1'b1;
					result.drive_enables = (item.switch_offset == SW_SEL_SECOND) ?
						EN_SECOND : EN_FIRST;
				end

				if (!cfg.controller_kind) begin
					if (item.switch_offset == SW_DATA) begin
						if (lines[LN_Q7]) begin
							result.drive_write      = 1'b1;
							result.drive_write_byte = wlatch_q;
						end else if (item.req_type == REQ_READ) begin
							result.read_value       = item.drive_byte;
							result.drive_read_taken = 1'b1;
						end
					end else if (item.req_type == REQ_READ &&
							(item.switch_offset == SW_LATCH ||
							item.switch_offset == SW_STATUS_ALT)) begin
						result.read_value = status;
					end else if (item.req_type == REQ_WRITE &&
							item.switch_offset == SW_LATCH) begin
						wlatch_d = item.bus_data;
					end
				end else if (item.req_type == REQ_READ) begin
					if (!item.switch_offset[0]) begin
						case ({lines[LN_Q7], lines[LN_Q6]})
							SEL_DATA: begin
								if (pair || !lines[LN_MOTOR]) begin
									result.read_value = BYTE_ALL;
								end else begin
									result.read_value       = item.drive_byte;
									result.drive_read_taken = 1'b1;
								end
							end
							SEL_STATUS: result.read_value = status;
							SEL_HANDSHAKE: begin
								if (pair) begin
									hs_d              = hs_inc;
									result.read_value = (hs_inc != 2'd0) ? HS_BUSY : HS_READY;
								end else begin
									result.read_value = HS_READY;
								end
							end
							default: ;
						endcase
					end
				end else begin
					if (item.switch_offset[0] && lines[LN_Q6] && lines[LN_Q7]) begin
						if (!lines[LN_MOTOR]) begin
							mode_d = item.bus_data[4:0];
						end else if (!pair) begin
							result.drive_write      = 1'b1;
							result.drive_write_byte = item.bus_data;
						end
					end
				end

				if (ev_on || ev_off) begin
					pend_d               = 1'b0;
					cnt_d                = '0;
					ctrl_d[LN_MOTOR]     = ev_on;
					result.enable_update = 1'b1;
					if (ev_off && cfg.controller_kind)
						result.drive_enables = EN_NONE;
					else
						result.drive_enables = lines[LN_DRIVE] ? EN_SECOND : EN_FIRST;
				end
			end
			default: ;
		endcase

		result.phase_lines = ctrl_d[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q   <= '0;
			mode_q   <= MODE_RESET;
			wlatch_q <= '0;
			hs_q     <= '0;
			pend_q   <= 1'b0;
			cnt_q    <= '0;
		end else if (step_en) begin
			ctrl_q   <= ctrl_d;
			mode_q   <= mode_d;
			wlatch_q <= wlatch_d;
			hs_q     <= hs_d;
			pend_q   <= pend_d;
			cnt_q    <= cnt_d;
		end
	end

	`FSSC_ASSERT(a_pend_count, clk, arst_n, pend_q == (cnt_q != '0), "pending turn-off out of step with countdown")
	`FSSC_ASSERT(a_hs_hold, clk, arst_n, !step_en |=> $stable(hs_q), "handshake count moved without a step")
	`FSSC_ASSERT(a_second_drive, clk, arst_n, step_en && result.enable_update && result.drive_enables == EN_SECOND |=> ctrl_q[LN_DRIVE], "second drive reported with drive line clear")

endmodule

// File: rtl/floppy_softswitch_controller.sv
`timescale 1ns / 1ps
// An accepted request passes through the input register and then the result register.
// Throughput: one request per cycle unless stalled; all state updates fit in one compute stage.
// Backpressure on the result side stalls the input register, which then drops in_ready.
// Reset (arst_n low, asynchronous): control lines, handshake count and motor timer clear,
// mode bits go to all ones, controller_kind to integrated, motor_off_ticks to 1000000.
`include "floppy_softswitch_controller_defines.svh"
module floppy_softswitch_controller #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [3:0]  switch_offset,
	input  logic [7:0]  bus_data,
	input  logic [7:0]  drive_byte,
	input  logic        drive_sense,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_value,
	output logic        phase_update,
	output logic [3:0]  phase_lines,
	output logic        enable_update,
	output logic [1:0]  drive_enables,
	output logic        drive_write,
	output logic [7:0]  drive_write_byte,
	output logic        drive_read_taken,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import fssc_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	result_t res_next;
	logic    out_valid_q;
	logic    advance;
	logic    cfg_wr;

	// Configuration: zero-wait-state port, register picked by the word address bit.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.controller_kind <= 1'b1;
			cfg_q.motor_off_ticks <= TICKS_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_KIND)
				cfg_q.controller_kind <= pwdata[0];
			else
				cfg_q.motor_off_ticks <= pwdata[TICKS_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_KIND:  prdata = {31'd0, cfg_q.controller_kind};
			REG_TICKS: prdata = 32'(cfg_q.motor_off_ticks);
			default:   prdata = '0;
		endcase
	end

	// Advance the input stage whenever the result register is empty or being drained;
	// accept a new transfer whenever the input stage will be free.
	assign advance  = ~out_valid_q | out_ready;
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	// Payload of the input stage: hold while stalled, load on every free cycle.
	always_ff @(posedge clk) begin
		if (in_ready) begin
			item_s1.req_type      <= req_type;
			item_s1.switch_offset <= switch_offset;
			item_s1.bus_data      <= bus_data;
			item_s1.drive_byte    <= drive_byte;
			item_s1.drive_sense   <= drive_sense;
		end
	end

	// Compute the result and commit state in the same cycle the item leaves stage one.
	fssc_engine #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(valid_s1 & advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= valid_s1;
	end

	// Result register: hold while the consumer stalls.
	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			res_s2 <= res_next;
	end

	assign out_valid        = out_valid_q;
	assign read_value       = res_s2.read_value;
	assign phase_update     = res_s2.phase_update;
	assign phase_lines      = res_s2.phase_lines;
	assign enable_update    = res_s2.enable_update;
	assign drive_enables    = res_s2.drive_enables;
	assign drive_write      = res_s2.drive_write;
	assign drive_write_byte = res_s2.drive_write_byte;
	assign drive_read_taken = res_s2.drive_read_taken;

	`FSSC_ASSERT(a_stall_only_full, clk, arst_n, !in_ready |-> valid_s1 && out_valid_q && !out_ready, "input stalled with room downstream")
	`FSSC_ASSERT(a_result_kept, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(res_s2), "stalled result changed")
	`FSSC_ASSERT(a_enable_code, clk, arst_n, out_valid |-> drive_enables != 2'd3, "illegal enable code")

endmodule
